FILE: rtl/core/assert_macros.svh
// Assertion helpers; every user has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NWC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define NWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/nwc_pkg.sv
package nwc_pkg;

  localparam int unsigned MAX_WIDTH  = 128;
  localparam int unsigned MAX_HEIGHT = 128;
  localparam int unsigned MAX_KERNEL = 8;
  localparam int unsigned DATA_WIDTH = 16;

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
  localparam int unsigned KIDX_W  = $clog2(MAX_KERNEL);
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned KCFG_W  = 4;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned PROD_W  = 2 * DATA_WIDTH;
  localparam int unsigned ACC_W   = 38;
  localparam int unsigned KSUM_W  = 23;
  localparam int unsigned DCNT_W  = $clog2(ACC_W + 1);
  localparam int unsigned LADDR_W = KIDX_W + COL_W;
  localparam int unsigned KADDR_W = 2 * KIDX_W;

  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_KSIZE  = 2'd2;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KSUM,
    S_MAC,
    S_DIV,
    S_OUT
  } state_t;

  // clamp an image dimension into 1..max
  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                               input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [KCFG_W-1:0] eff_ksz(input logic [KCFG_W-1:0] v);
    logic [KCFG_W-1:0] r;
    r = v;
    if (v == '0) r = KCFG_W'(1);
    else if (v > KCFG_W'(MAX_KERNEL)) r = KCFG_W'(MAX_KERNEL);
    return r;
  endfunction

endpackage

FILE: rtl/core/nwc_if.sv
interface nwc_pix_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic [nwc_pkg::KIDX_W-1:0]           coef_row;
  logic [nwc_pkg::KIDX_W-1:0]           coef_col;
  logic signed [nwc_pkg::DATA_WIDTH-1:0] value;
  modport source (output valid, op, coef_row, coef_col, value, input ready);
  modport sink   (input valid, op, coef_row, coef_col, value, output ready);
endinterface

interface nwc_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [nwc_pkg::ACC_W-1:0] filtered_value;
  logic [nwc_pkg::ROW_W-1:0]        out_row;
  logic [nwc_pkg::COL_W-1:0]        out_col;
  logic                             status;
  modport source (output valid, filtered_value, out_row, out_col, status, input ready);
  modport sink   (input valid, filtered_value, out_row, out_col, status, output ready);
endinterface

interface nwc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [nwc_pkg::CIDX_W-1:0]   index;
  logic [nwc_pkg::CFG_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/normalized_window_convolution.sv
// channel  dir  handshake     payload
// in_ch    in   valid/ready   op, coef_row, coef_col, value
// out_ch   out  valid/ready   filtered_value, out_row, out_col, status
// cfg_ch   in   valid/ready   index, data (cfg_ch.ready is always high)
// A coefficient transfer starts a kernel sum pass: the kernel sum is re-read from the kernel RAM.
// A pixel that closes a window is multiply-accumulated through the single multiplier, then
// divided in the bit-serial divider and output; with a zero kernel sum it goes straight to output.
// A kernel_size write triggers the same kernel sum pass before the next item.
// Reset (rst_n low, synchronous) clears counters, kernel sum and control; the RAMs keep data.
// A finished result sits in the output register; the next item may be taken meanwhile.
`include "assert_macros.svh"

module normalized_window_convolution (
  input  logic      clk,
  input  logic      rst_n,
  nwc_pix_if.sink   in_ch,
  nwc_res_if.source out_ch,
  nwc_cfg_if.sink   cfg_ch
);

  localparam int unsigned DW = nwc_pkg::DATA_WIDTH;
  localparam int unsigned AW = nwc_pkg::ACC_W;
  localparam int unsigned KW = nwc_pkg::KSUM_W;
  localparam int unsigned CFW = nwc_pkg::CFG_W;
  localparam int unsigned KCW = nwc_pkg::KCFG_W;
  localparam int unsigned RW = nwc_pkg::ROW_W;
  localparam int unsigned CLW = nwc_pkg::COL_W;
  localparam int unsigned XW = nwc_pkg::KIDX_W;
  localparam int unsigned PW = nwc_pkg::PROD_W;

  nwc_pkg::state_t state_r, state_nxt;

  logic [CFW-1:0] width_r, height_r;
  logic [KCW-1:0] ksize_r;
  logic           ksum_req_r;
  logic [RW-1:0]  row_r;
  logic [CLW-1:0] col_r;
  logic signed [KW-1:0] kernel_sum_r, ksum_acc_r, ksum_add;

  logic [CFW-1:0] w_eff, h_eff;
  logic [KCW-1:0] k_eff;

  // config
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFW'(nwc_pkg::MAX_WIDTH);
      height_r <= CFW'(nwc_pkg::MAX_HEIGHT);
      ksize_r  <= KCW'(3);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        nwc_pkg::REG_WIDTH:  width_r  <= cfg_ch.data;
        nwc_pkg::REG_HEIGHT: height_r <= cfg_ch.data;
        nwc_pkg::REG_KSIZE:  ksize_r  <= cfg_ch.data[KCW-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = nwc_pkg::eff_dim(width_r, CFW'(nwc_pkg::MAX_WIDTH));
  assign h_eff = nwc_pkg::eff_dim(height_r, CFW'(nwc_pkg::MAX_HEIGHT));
  assign k_eff = nwc_pkg::eff_ksz(ksize_r);

  // pixel position
  logic           in_fire, is_pix, emit;
  logic           wrap_c;
  logic [CFW-1:0] r_ext, r_tmp, c_ext, r_inc, c_inc, k_ext;
  logic [RW-1:0]  r_cur, row_nxt, r0_calc;
  logic [CLW-1:0] c_cur, col_nxt, c0_calc;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign is_pix  = in_ch.op == nwc_pkg::OP_PIXEL;

  always_comb begin
    k_ext  = CFW'(k_eff);
    wrap_c = {1'b0, col_r} >= w_eff;
    c_cur  = wrap_c ? '0 : col_r;
    r_tmp  = wrap_c ? {1'b0, row_r} + CFW'(1) : {1'b0, row_r};
    r_cur  = (r_tmp >= h_eff) ? '0 : r_tmp[RW-1:0];
    r_ext  = {1'b0, r_cur};
    c_ext  = {1'b0, c_cur};
    r_inc  = r_ext + CFW'(1);
    c_inc  = c_ext + CFW'(1);
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
    end else begin
      col_nxt = c_inc[CLW-1:0];
      row_nxt = r_cur;
    end
    emit    = (k_ext <= w_eff) && (k_ext <= h_eff) && (r_inc >= k_ext) && (c_inc >= k_ext);
    r0_calc = RW'(r_inc - k_ext);
    c0_calc = CLW'(c_inc - k_ext);
  end

  // window walk over x,y
  logic [XW-1:0]  x_r, y_r;
  logic           walk_done_r, rd_vld_r, rd_last_r, prod_vld_r, prod_last_r;
  logic           walk_last, issue, out_load, out_free;
  logic [RW-1:0]  r0_r;
  logic [CLW-1:0] c0_r;
  logic signed [DW-1:0] kq, lq;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [AW-1:0] res_val_r, div_q;
  logic           res_status_r, div_done, div_start;

  assign walk_last = ({1'b0, x_r} == k_eff - KCW'(1)) && ({1'b0, y_r} == k_eff - KCW'(1));
  assign out_free  = !out_ch.valid || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nwc_pkg::S_IDLE: begin
        if (ksum_req_r) begin
          state_nxt = nwc_pkg::S_KSUM;
        end else if (in_fire) begin
          if (!is_pix) state_nxt = nwc_pkg::S_KSUM;
          else if (emit) state_nxt = (kernel_sum_r == '0) ? nwc_pkg::S_OUT : nwc_pkg::S_MAC;
        end
      end
      nwc_pkg::S_KSUM: if (rd_last_r) state_nxt = nwc_pkg::S_IDLE;
      nwc_pkg::S_MAC:  if (prod_last_r) state_nxt = nwc_pkg::S_DIV;
      nwc_pkg::S_DIV:  if (div_done) state_nxt = nwc_pkg::S_OUT;
      nwc_pkg::S_OUT:  if (out_free) state_nxt = nwc_pkg::S_IDLE;
      default:         state_nxt = nwc_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    out_load    = 1'b0;
    div_start   = 1'b0;
    case (state_r)
      nwc_pkg::S_IDLE: in_ch.ready = !ksum_req_r;
      nwc_pkg::S_KSUM: issue = !walk_done_r;
      nwc_pkg::S_MAC: begin
        issue     = !walk_done_r;
        div_start = prod_last_r;
      end
      nwc_pkg::S_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nwc_pkg::S_IDLE;
      ksum_req_r   <= 1'b0;
      row_r        <= '0;
      col_r        <= '0;
      kernel_sum_r <= '0;
      walk_done_r  <= 1'b0;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
      prod_vld_r   <= 1'b0;
      prod_last_r  <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.index == nwc_pkg::REG_KSIZE) begin
        ksum_req_r <= 1'b1;
      end else if (state_r == nwc_pkg::S_IDLE) begin
        ksum_req_r <= 1'b0;
      end
      if (in_fire && is_pix) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (state_r == nwc_pkg::S_IDLE) begin
        walk_done_r <= 1'b0;
        rd_vld_r    <= 1'b0;
        rd_last_r   <= 1'b0;
        prod_vld_r  <= 1'b0;
        prod_last_r <= 1'b0;
      end else begin
        rd_vld_r    <= issue;
        rd_last_r   <= issue && walk_last;
        prod_vld_r  <= rd_vld_r && state_r == nwc_pkg::S_MAC;
        prod_last_r <= rd_last_r && state_r == nwc_pkg::S_MAC;
        if (issue && walk_last) walk_done_r <= 1'b1;
      end
      if (state_r == nwc_pkg::S_KSUM && rd_last_r) begin
        kernel_sum_r <= ksum_add;
      end
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  assign ksum_add = ksum_acc_r + KW'(kq);
  assign acc_nxt  = acc_r + AW'(prod_r);

  always_ff @(posedge clk) begin
    if (state_r == nwc_pkg::S_IDLE) begin
      x_r        <= '0;
      y_r        <= '0;
      ksum_acc_r <= '0;
      acc_r      <= '0;
    end else begin
      if (issue) begin
        if ({1'b0, y_r} == k_eff - KCW'(1)) begin
          y_r <= '0;
          x_r <= x_r + XW'(1);
        end else begin
          y_r <= y_r + XW'(1);
        end
      end
      if (rd_vld_r) ksum_acc_r <= ksum_add;
      if (prod_vld_r) acc_r <= acc_nxt;
    end
    if (rd_vld_r) prod_r <= PW'(kq) * PW'(lq);
    if (in_fire && is_pix) begin
      r0_r         <= r0_calc;
      c0_r         <= c0_calc;
      res_val_r    <= '0;
      res_status_r <= 1'b1;
    end else if (div_done) begin
      res_val_r    <= div_q;
      res_status_r <= 1'b0;
    end
    if (out_load) begin
      out_ch.filtered_value <= res_val_r;
      out_ch.out_row        <= r0_r;
      out_ch.out_col        <= c0_r;
      out_ch.status         <= res_status_r;
    end
  end

  nwc_ram #(.DATA_W(DW), .ADDR_W(nwc_pkg::KADDR_W)) u_kram (
    .clk   (clk),
    .we    (in_fire && !is_pix),
    .waddr ({in_ch.coef_row, in_ch.coef_col}),
    .wdata (in_ch.value),
    .raddr ({x_r, y_r}),
    .rdata (kq)
  );

  nwc_ram #(.DATA_W(DW), .ADDR_W(nwc_pkg::LADDR_W)) u_lram (
    .clk   (clk),
    .we    (in_fire && is_pix),
    .waddr ({r_cur[XW-1:0], c_cur}),
    .wdata (in_ch.value),
    .raddr ({XW'(r0_r + RW'(x_r)), CLW'(c0_r + CLW'(y_r))}),
    .rdata (lq)
  );

  nwc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_nxt),
    .divisor  (kernel_sum_r),
    .done     (div_done),
    .quotient (div_q)
  );

  `NWC_ASSERT_NOW(a_done_in_div, div_done, state_r == nwc_pkg::S_DIV)
  `NWC_ASSERT_NEXT(a_coef_sums, in_fire && !is_pix, state_r == nwc_pkg::S_KSUM)
  `NWC_ASSERT_NEXT(a_load_shows, out_load, out_ch.valid)
  `NWC_ASSERT_NOW(a_no_issue_idle, state_r == nwc_pkg::S_IDLE, !issue && !rd_vld_r)

endmodule

FILE: rtl/core/nwc_ram.sv
module nwc_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/nwc_div.sv
`include "assert_macros.svh"

module nwc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [nwc_pkg::ACC_W-1:0]  dividend,
  input  logic signed [nwc_pkg::KSUM_W-1:0] divisor,
  output logic                              done,
  output logic signed [nwc_pkg::ACC_W-1:0]  quotient
);

  localparam int unsigned AW = nwc_pkg::ACC_W;
  localparam int unsigned KW = nwc_pkg::KSUM_W;
  localparam int unsigned CW = nwc_pkg::DCNT_W;

  logic [AW-1:0] quo_r, quo_nxt;
  logic [KW-1:0] rem_r, rem_nxt, dmag_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r, busy_r, done_r;
  logic [KW:0]   rem_sh, rem_sub;
  logic          ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh  = {rem_r, quo_r[AW-1]};
    rem_sub = rem_sh - {1'b0, dmag_r};
    ge      = rem_sh >= {1'b0, dmag_r};
    rem_nxt = ge ? rem_sub[KW-1:0] : rem_sh[KW-1:0];
    quo_nxt = {quo_r[AW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(AW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dividend[AW-1] ^ divisor[KW-1];
      quo_r  <= dividend[AW-1] ? AW'(-dividend) : AW'(dividend);
      dmag_r <= divisor[KW-1] ? KW'(-divisor) : KW'(divisor);
      rem_r  <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

  `NWC_ASSERT_NOW(a_div_no_restart, busy_r, !start)
  `NWC_ASSERT_NEXT(a_div_done_ends, done_r, !busy_r && !done_r)
  `NWC_ASSERT_NOW(a_div_nonzero, start, divisor != '0)

endmodule
